// ===== rtl/core/itp_pkg.sv =====
// Shared types, constants and helper functions for the infix to postfix converter.
// Used by itp_ctrl, itp_datapath and infix_to_postfix_converter. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Field widths
  localparam int CH_W     = 8;
  localparam int STATUS_W = 2;

  // Character codes
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CH_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CH_W-1:0] CH_POW   = 8'h5E;
  localparam logic [CH_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CH_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CH_W-1:0] CH_END   = 8'h24;
  localparam logic [CH_W-1:0] SYM_NONE = 8'h00;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNMATCH  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FREAD,
    S_FEVAL
  } state_t;

  // Character classes
  typedef enum logic [1:0] {
    CLS_OPND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_ARITH
  } cls_t;

  // Source of an emitted symbol
  typedef enum logic [1:0] {
    EMIT_CH,
    EMIT_TOP,
    EMIT_NONE
  } emit_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                latch;
    logic                rd_en;
    logic                push;
    logic                pop;
    logic                set_open;
    logic                emit;
    emit_sel_t           sel;
    logic                run_end;
    logic [STATUS_W-1:0] status;
  } itp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cls_t             cls;
    logic             cnt_zero;
    logic             cnt_full;
    logic             top_open;
    logic             top_pops;
    logic             last;
    logic             open_left;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } itp_stat_t;

  // Operator precedence; ( and anything else is 0
  function automatic logic [1:0] prec_of(input logic [CH_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_POW) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_arith(input logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
           (c == CH_DIV) || (c == CH_POW);
  endfunction

  function automatic cls_t class_of(input logic [CH_W-1:0] c);
    cls_t k;
    if (c == CH_OPEN) k = CLS_OPEN;
    else if (c == CH_CLOSE) k = CLS_CLOSE;
    else if (is_arith(c)) k = CLS_ARITH;
    else k = CLS_OPND;
    return k;
  endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter (shunting-yard with an operator stack).
// Instantiates itp_ctrl and itp_datapath; depends on itp_pkg.
//
// Usage: characters of an infix expression enter one per transaction on the
// in_ channel; in_tlast marks the final character of a run. Postfix symbols
// leave on the out_ channel with a status code in out_tuser; the result that
// closes a run carries out_tlast. Operands pass through, operators and ( go
// to a 32-entry stack memory with a registered read port.
// Timing: a character is taken only when the controller is idle. An operand
// or a push passes through the accepting idle state, a stack read and one
// decision before the next character is taken; each stacked operator popped
// adds one memory read and one decision. The flush after a last character
// reads and decides once per stacked entry, then emits the end result.
// The first result passes the input latch and the stack read, then the output register.
// Reset empties the stack and drops any pending result; stack contents are
// not cleared. When the receiver stalls, the single output register holds its
// transaction and the controller waits before emitting the next one; a new
// character may still be accepted while a finished result waits.
`timescale 1ns / 1ps

module infix_to_postfix_converter import itp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] ch
  input  logic                in_tlast,   // last
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] sym
  output logic                out_tlast,  // run_end
  output logic [STATUS_W-1:0] out_tuser   // [1:0] status
);

  itp_cmd_t  cmd;
  itp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  itp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_tdata),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_sym     (out_tdata),
    .out_run_end (out_tlast),
    .out_status  (out_tuser)
  );

  // Stack count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A status result carries no symbol
  a_status_nosym: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata == SYM_NONE))
    else $error("status result with a symbol");

  // End of run reports only ok or unclosed paren, with no symbol
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (((out_tuser == ST_OK) || (out_tuser == ST_UNCLOSED)) && (out_tdata == SYM_NONE)))
    else $error("bad end-of-run result");

  // No push, pop or emit while a character is being accepted
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!cmd.push && !cmd.pop && !cmd.emit))
    else $error("stack or output touched on accept");

endmodule

// ===== rtl/core/itp_datapath.sv =====
// Datapath of the infix to postfix converter: input latch, operator stack memory,
// stack count, precedence compare and output register. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_datapath import itp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CH_W-1:0]     in_ch,
  input  logic                in_last,
  input  itp_cmd_t            cmd,
  output itp_stat_t           stat,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [CH_W-1:0]     out_sym,
  output logic                out_run_end,
  output logic [STATUS_W-1:0] out_status
);

  logic [CH_W-1:0]     stack_mem [STACK_DEPTH];
  logic [CH_W-1:0]     ch_r;
  logic                last_r;
  logic                open_r;
  logic [CH_W-1:0]     top_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    count_m1;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                out_valid_r;
  logic [CH_W-1:0]     sym_r;
  logic                run_end_r;
  logic [STATUS_W-1:0] status_r;
  logic [1:0]          p_in;
  logic [1:0]          q_top;

  assign count_m1 = count_r - CNT_W'(1);
  assign rd_addr  = count_m1[IDX_W-1:0];
  assign wr_addr  = count_r[IDX_W-1:0];

  // Input character latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  // Stack memory: one write port, registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[wr_addr] <= ch_r;
    end
    if (cmd.rd_en) begin
      top_r <= stack_mem[rd_addr];
    end
  end

  // Stack count
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) count_nxt = count_r + CNT_W'(1);
    else if (cmd.pop) count_nxt = count_m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Unclosed paren flag for the flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (cmd.latch) begin
      open_r <= 1'b0;
    end else if (cmd.set_open) begin
      open_r <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        EMIT_CH:  sym_r <= ch_r;
        EMIT_TOP: sym_r <= top_r;
        default:  sym_r <= SYM_NONE;
      endcase
      run_end_r <= cmd.run_end;
      status_r  <= cmd.status;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_sym     = sym_r;
  assign out_run_end = run_end_r;
  assign out_status  = status_r;

  // Precedence compare: + - * / pop on >=, ^ pops on > only
  assign p_in  = prec_of(ch_r);
  assign q_top = prec_of(top_r);

  always_comb begin
    stat.cls       = class_of(ch_r);
    stat.cnt_zero  = (count_r == '0);
    stat.cnt_full  = (count_r == CNT_W'(STACK_DEPTH));
    stat.top_open  = (top_r == CH_OPEN);
    stat.top_pops  = is_arith(top_r) &&
                     ((q_top > p_in) || ((ch_r != CH_POW) && (q_top == p_in)));
    stat.last      = last_r;
    stat.open_left = open_r;
    stat.out_free  = !out_valid_r || out_tready;
    stat.count     = count_r;
  end

endmodule

// ===== rtl/core/itp_ctrl.sv =====
// Controller state machine of the infix to postfix converter: sequences stack
// reads, pops, pushes and result transactions. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_ctrl import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  itp_stat_t stat,
  output itp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.sel   = EMIT_NONE;
    cmd.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end

      // Fetch top of stack
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end

      // One decision per character or per pop
      S_EVAL: begin
        case (stat.cls)
          CLS_OPND: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = EMIT_CH;
              state_nxt = stat.last ? S_FREAD : S_IDLE;
            end
          end
          CLS_CLOSE: begin
            if (stat.cnt_zero) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_UNMATCH;
                state_nxt  = stat.last ? S_FREAD : S_IDLE;
              end
            end else if (stat.top_open) begin
              cmd.pop   = 1'b1;
              state_nxt = stat.last ? S_FREAD : S_IDLE;
            end else if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = EMIT_TOP;
              cmd.pop   = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
            // Open paren, or arithmetic operator once nothing more pops
            if ((stat.cls == CLS_ARITH) && !stat.cnt_zero && stat.top_pops) begin
              if (stat.out_free) begin
                cmd.emit  = 1'b1;
                cmd.sel   = EMIT_TOP;
                cmd.pop   = 1'b1;
                state_nxt = S_READ;
              end
            end else if (!stat.cnt_full) begin
              cmd.push  = 1'b1;
              state_nxt = stat.last ? S_FREAD : S_IDLE;
            end else if (stat.out_free) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_OVERFLOW;
              state_nxt  = stat.last ? S_FREAD : S_IDLE;
            end
          end
        endcase
      end

      S_FREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FEVAL;
      end

      // Flush: drain the stack, then close the run
      S_FEVAL: begin
        if (stat.cnt_zero) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.run_end = 1'b1;
            cmd.status  = stat.open_left ? ST_UNCLOSED : ST_OK;
            state_nxt   = S_IDLE;
          end
        end else if (stat.top_open) begin
          cmd.pop      = 1'b1;
          cmd.set_open = 1'b1;
          state_nxt    = S_FREAD;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EMIT_TOP;
          cmd.pop   = 1'b1;
          state_nxt = S_FREAD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== test/infix_to_postfix_converter_tb.sv =====
// Self-checking testbench for infix_to_postfix_converter: random stream traffic with
// a shunting-yard predictor checked result by result. Depends on itp_pkg and the RTL.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 85;
  localparam int IDLE_LIMIT     = 3000;
  localparam int DRAIN_CYCLES   = 2 * STACK_DEPTH + 10;

  // One input character and one postfix result
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            fin;
  } infix_char_t;

  typedef struct packed {
    logic [CH_W-1:0]     sym;
    logic                run_end;
    logic [STATUS_W-1:0] status;
  } postfix_sym_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = 8'h00;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                out_tlast;
  logic [STATUS_W-1:0] out_tuser;

  infix_char_t  infix_chars [$];
  postfix_sym_t postfix_due [$];

  // Predictor copy of the operator stack
  logic [CH_W-1:0] held_ops [STACK_DEPTH];
  int              held_cnt = 0;

  int          n_items     = 0;
  int          items_taken = 0;
  int          fails       = 0;
  int          idle_cycles = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  bit          in_quiet    = 1'b0;
  bit          out_quiet   = 1'b0;
  logic        drv_free;
  postfix_sym_t got;

  infix_to_postfix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Precedence; 0 for ( and for operands
  function automatic int rank(input logic [CH_W-1:0] c);
    case (c)
      CH_PLUS, CH_MINUS: return 1;
      CH_MUL, CH_DIV:    return 2;
      CH_POW:            return 3;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] op_code(input int k);
    case (k)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      4:       return CH_POW;
      5:       return CH_OPEN;
      default: return CH_CLOSE;
    endcase
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CH_W-1:0] pick_operand();
    logic [CH_W-1:0] c;
    if ($urandom_range(0, 1) == 0) return 8'h61 + CH_W'($urandom_range(0, 25));
    do c = CH_W'($urandom_range(0, 255));
    while (rank(c) != 0 || c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  task automatic emit(input logic [CH_W-1:0] s, input logic e, input logic [STATUS_W-1:0] st);
    postfix_due.push_back('{sym: s, run_end: e, status: st});
  endtask

  task automatic push_op(input logic [CH_W-1:0] c);
    if (held_cnt < STACK_DEPTH) begin
      held_ops[held_cnt] = c;
      held_cnt++;
    end else begin
      emit(SYM_NONE, 1'b0, ST_OVERFLOW);
    end
  endtask

  // Shunting-yard step for one accepted character
  task automatic shunt_char(input logic [CH_W-1:0] c, input logic fin);
    logic [CH_W-1:0] t;
    logic            found;
    logic            open_left;
    int              p;
    p = rank(c);
    if (c == CH_OPEN) begin
      push_op(c);
    end else if (c == CH_CLOSE) begin
      found = 1'b0;
      while (held_cnt > 0 && !found) begin
        t = held_ops[held_cnt-1];
        held_cnt--;
        if (t == CH_OPEN) found = 1'b1;
        else emit(t, 1'b0, ST_OK);
      end
      if (!found) emit(SYM_NONE, 1'b0, ST_UNMATCH);
    end else if (p != 0) begin
      // ^ pops only strictly higher, the others pop equal too
      while (held_cnt > 0 && held_ops[held_cnt-1] != CH_OPEN &&
             (rank(held_ops[held_cnt-1]) > p ||
              (c != CH_POW && rank(held_ops[held_cnt-1]) == p))) begin
        emit(held_ops[held_cnt-1], 1'b0, ST_OK);
        held_cnt--;
      end
      push_op(c);
    end else begin
      emit(c, 1'b0, ST_OK);
    end
    // Flush on the final character of a run
    if (fin) begin
      open_left = 1'b0;
      while (held_cnt > 0) begin
        t = held_ops[held_cnt-1];
        held_cnt--;
        if (t == CH_OPEN) open_left = 1'b1;
        else emit(t, 1'b0, ST_OK);
      end
      emit(SYM_NONE, 1'b1, open_left ? ST_UNCLOSED : ST_OK);
    end
  endtask

  task automatic add_char(input logic [CH_W-1:0] c, input logic fin);
    infix_chars.push_back('{ch: c, fin: fin});
    n_items++;
  endtask

  task automatic add_run(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endtask

  // Well-formed expression with random operands, operators and nesting
  task automatic add_expr(input int terms);
    int opens;
    opens = 0;
    for (int i = 0; i < terms; i++) begin
      while (opens < 6 && $urandom_range(0, 3) == 0) begin
        add_char(CH_OPEN, 1'b0);
        opens++;
      end
      add_char(pick_operand(), 1'b0);
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CH_CLOSE, 1'b0);
        opens--;
      end
      if (i < terms - 1) add_char(op_code($urandom_range(0, 4)), 1'b0);
    end
    while (opens > 0) begin
      add_char(CH_CLOSE, 1'b0);
      opens--;
    end
    infix_chars[infix_chars.size()-1].fin = 1'b1;
  endtask

  // Broken run: operators, parens and bytes in any order
  task automatic add_noise();
    int n;
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) add_char(op_code($urandom_range(0, 6)), i == n - 1);
      else add_char(CH_W'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // Fill the stack past its depth with ( and ^, then unwind partly
  task automatic add_deep();
    int n;
    n = STACK_DEPTH + $urandom_range(1, 3);
    add_char(pick_operand(), 1'b0);
    for (int i = 0; i < n; i++)
      add_char($urandom_range(0, 1) ? CH_OPEN : CH_POW, 1'b0);
    add_char(op_code($urandom_range(0, 3)), 1'b0);
    add_char(pick_operand(), 1'b0);
    add_char(CH_CLOSE, 1'b0);
    add_char(pick_operand(), 1'b1);
  endtask

  // Driver: presents queued characters, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drv_free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        shunt_char(in_tdata, in_tlast);
        items_taken++;
        drv_free = 1'b1;
        gap_left = (in_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_len();
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
      end
      if (drv_free) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (infix_chars.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= infix_chars[0].ch;
          in_tlast  <= infix_chars[0].fin;
          void'(infix_chars.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{sym: out_tdata, run_end: out_tlast, status: out_tuser};
        if (postfix_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result sym %h end %b status %0d", $time,
                   got.sym, got.run_end, got.status);
        end else begin
          if (got !== postfix_due[0]) begin
            fails++;
            $display("%0t: mismatch expected sym %h end %b status %0d, got sym %h end %b status %0d",
                     $time, postfix_due[0].sym, postfix_due[0].run_end, postfix_due[0].status,
                     got.sym, got.run_end, got.status);
          end
          void'(postfix_due.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!out_quiet && $urandom_range(0, 5) == 0) stall_left = pick_len();
      end
      if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("infix_to_postfix_converter_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int runs;
    int deep_at;
    // Directed: associativity, parens, boundary bytes, error cases
    add_run("(a+b)*c-$");
    add_run("x^y^z/w");
    add_run("p-q)+");
    add_char(8'h00, 1'b0);
    add_char(CH_OPEN, 1'b0);
    add_char(8'hFF, 1'b1);
    add_char(CH_CLOSE, 1'b1);
    // Random runs, one of them overflowing the stack
    runs = 0;
    deep_at = $urandom_range(0, 2);
    while (n_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (runs == deep_at) add_deep();
      else if ($urandom_range(0, 5) == 0) add_noise();
      else add_expr($urandom_range(1, 6));
      runs++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != n_items) @(posedge clk);
    while (postfix_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && postfix_due.size() == 0) begin
      $display("infix_to_postfix_converter_tb passed");
    end else begin
      $display("infix_to_postfix_converter_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/itp_pkg.sv
rtl/core/itp_datapath.sv
rtl/core/itp_ctrl.sv
rtl/core/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
